// File: src/mfn_pkg.sv
// ----------------------------------------------------------------------------
// Mesh face normal engine package
// Shared constants, codes and the sideband type that travels with an item
// through the normalisation stages.
// ----------------------------------------------------------------------------
package mfn_pkg;

	// Default sizes of the vertex table and of one coordinate.
	localparam int unsigned VERTEX_DEPTH_DEF = 4096;
	localparam int unsigned COORD_BITS_DEF   = 16;

	// Index ports and the width used to compare an index against the depth.
	localparam int unsigned INDEX_BITS     = 12;
	localparam int unsigned INDEX_EXT_BITS = 17;

	// Result and normalisation widths.
	localparam int unsigned OUT_BITS   = 36;
	localparam int unsigned MAG_BITS   = 31;
	localparam int unsigned SQ_BITS    = 2 * MAG_BITS;
	localparam int unsigned SUM_BITS   = 64;
	localparam int unsigned ROOT_STEPS = 32;
	localparam int unsigned ROOT_BITS  = 32;
	localparam int unsigned UNIT_SHIFT = 14;
	localparam int unsigned QUOT_BITS  = 15;
	// Dividend of the rounding division stays below 2^46.
	localparam int unsigned REM_BITS   = 46;

	// Configuration port.
	localparam int unsigned CFG_INDEX_BITS = 1;
	localparam int unsigned CFG_DATA_BITS  = 1;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_FACE = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_NORMALS_ENABLE   = 1'b0,
		REG_NORMALIZE_ENABLE = 1'b1
	} reg_index_t;

	// Per-item sideband carried alongside the root and divide stages.
	typedef struct packed {
		logic                           nrm;
		logic                           deg;
		logic [2:0]                     neg;
		logic [2:0][OUT_BITS-1:0]       raw;
		logic [2:0][MAG_BITS-1:0]       mag;
	} side_t;

endpackage

// File: src/mesh_face_normal_engine_core.sv
// Throughput: one item per cycle while the skid stage is not full; every stage is a register stage with a valid bit.
// The path is eight front stages, the sum and 32 one-bit square-root stages, the
// divide set-up and 15 divide stages, and the output register.
// A load item writes the vertex table at its accept edge and gives no result.
// Reset clears valid bits, the skid stage and both enables (to one); the vertex
// table is not cleared and a vertex must be loaded before a face reads it.
// ----------------------------------------------------------------------------
// Mesh face normal engine core
// Vertex table, cross product of corner differences and optional scaling to
// a unit normal in Q1.14, in one stallable pipeline with an output skid stage.
// ----------------------------------------------------------------------------
module mesh_face_normal_engine_core #(
	parameter int unsigned VERTEX_DEPTH = mfn_pkg::VERTEX_DEPTH_DEF,
	parameter int unsigned COORD_BITS   = mfn_pkg::COORD_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    op,
	input  logic [mfn_pkg::INDEX_BITS-1:0]          vertex_index,
	input  logic signed [COORD_BITS-1:0]            coord_x,
	input  logic signed [COORD_BITS-1:0]            coord_y,
	input  logic signed [COORD_BITS-1:0]            coord_z,
	input  logic [mfn_pkg::INDEX_BITS-1:0]          corner_a,
	input  logic [mfn_pkg::INDEX_BITS-1:0]          corner_b,
	input  logic [mfn_pkg::INDEX_BITS-1:0]          corner_c,
	input  logic [mfn_pkg::INDEX_BITS-1:0]          corner_d,
	input  logic                                    is_quad,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [mfn_pkg::OUT_BITS-1:0]     normal_x,
	output logic signed [mfn_pkg::OUT_BITS-1:0]     normal_y,
	output logic signed [mfn_pkg::OUT_BITS-1:0]     normal_z,
	output logic                                    degenerate,
	input  logic                                    cfg_write,
	input  logic [mfn_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [mfn_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

	localparam int unsigned ADDR_BITS  = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int unsigned WORD_BITS  = 3 * COORD_BITS;
	localparam int unsigned DIFF_BITS  = COORD_BITS + 1;
	localparam int unsigned PROD_BITS  = 2 * DIFF_BITS;
	localparam int unsigned CROSS_BITS = PROD_BITS + 1;
	localparam int unsigned SHIFT_BITS = $clog2(CROSS_BITS + 1);
	localparam int unsigned OUT_BITS   = mfn_pkg::OUT_BITS;
	localparam int unsigned MAG_BITS   = mfn_pkg::MAG_BITS;
	localparam int unsigned SQ_BITS    = mfn_pkg::SQ_BITS;
	localparam int unsigned SUM_BITS   = mfn_pkg::SUM_BITS;
	localparam int unsigned ROOT_STEPS = mfn_pkg::ROOT_STEPS;
	localparam int unsigned ROOT_BITS  = mfn_pkg::ROOT_BITS;
	localparam int unsigned QUOT_BITS  = mfn_pkg::QUOT_BITS;
	localparam int unsigned REM_BITS   = mfn_pkg::REM_BITS;
	localparam int unsigned UNIT_SHIFT = mfn_pkg::UNIT_SHIFT;
	localparam int unsigned IEXT       = mfn_pkg::INDEX_EXT_BITS;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic normals_en_q;
	logic normalize_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normals_en_q   <= 1'b1;
			normalize_en_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (mfn_pkg::reg_index_t'(cfg_index))
				mfn_pkg::REG_NORMALS_ENABLE:   normals_en_q   <= cfg_data[0];
				mfn_pkg::REG_NORMALIZE_ENABLE: normalize_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline enable: the whole pipeline moves unless the skid stage is full.
	// ------------------------------------------------------------------
	logic skid_full_q;
	logic out_v_q;
	logic en;
	logic accept;

	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;
	assign accept   = in_valid && !skid_full_q;

	// An index selects a table slot only when it lies below the depth.
	function automatic logic in_range(input logic [mfn_pkg::INDEX_BITS-1:0] idx);
		return IEXT'(idx) < IEXT'(VERTEX_DEPTH);
	endfunction

	// ------------------------------------------------------------------
	// Stage 1: vertex table, written by loads and read for all four corners.
	// ------------------------------------------------------------------
	logic                 load_we;
	logic [WORD_BITS-1:0] rd_a, rd_b, rd_c, rd_d;

	assign load_we = accept && (op == mfn_pkg::OP_LOAD) && in_range(vertex_index);

	mfn_vtx_ram #(
		.DEPTH     (VERTEX_DEPTH),
		.WIDTH     (WORD_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_ram_ab (
		.clk       (clk),
		.wr_en     (load_we),
		.wr_addr   (ADDR_BITS'(vertex_index)),
		.wr_data   ({coord_z, coord_y, coord_x}),
		.rd_en     (en),
		.rd_addr_a (ADDR_BITS'(corner_a)),
		.rd_addr_b (ADDR_BITS'(corner_b)),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	mfn_vtx_ram #(
		.DEPTH     (VERTEX_DEPTH),
		.WIDTH     (WORD_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_ram_cd (
		.clk       (clk),
		.wr_en     (load_we),
		.wr_addr   (ADDR_BITS'(vertex_index)),
		.wr_data   ({coord_z, coord_y, coord_x}),
		.rd_en     (en),
		.rd_addr_a (ADDR_BITS'(corner_c)),
		.rd_addr_b (ADDR_BITS'(corner_d)),
		.rd_data_a (rd_c),
		.rd_data_b (rd_d)
	);

	logic       v_s1;
	logic       quad_s1;
	logic       nrm_s1;
	logic [3:0] oor_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1   <= is_quad;
			nrm_s1    <= normalize_en_q;
			oor_s1[0] <= !in_range(corner_a);
			oor_s1[1] <= !in_range(corner_b);
			oor_s1[2] <= !in_range(corner_c);
			oor_s1[3] <= !in_range(corner_d);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: corner differences.
	// ------------------------------------------------------------------
	logic [3:0][WORD_BITS-1:0]   pt;
	logic signed [DIFF_BITS-1:0] da [3];
	logic signed [DIFF_BITS-1:0] db [3];
	logic signed [DIFF_BITS-1:0] a_s2 [3];
	logic signed [DIFF_BITS-1:0] b_s2 [3];
	logic                        v_s2;
	logic                        nrm_s2;

	function automatic logic signed [DIFF_BITS-1:0] sub(input logic [COORD_BITS-1:0] p,
			input logic [COORD_BITS-1:0] q);
		return DIFF_BITS'($signed(p)) - DIFF_BITS'($signed(q));
	endfunction

	// A corner beyond the table reads as the origin.
	assign pt[0] = oor_s1[0] ? '0 : rd_a;
	assign pt[1] = oor_s1[1] ? '0 : rd_b;
	assign pt[2] = oor_s1[2] ? '0 : rd_c;
	assign pt[3] = oor_s1[3] ? '0 : rd_d;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (quad_s1) begin
				da[c] = sub(pt[2][c*COORD_BITS +: COORD_BITS], pt[0][c*COORD_BITS +: COORD_BITS]);
				db[c] = sub(pt[3][c*COORD_BITS +: COORD_BITS], pt[1][c*COORD_BITS +: COORD_BITS]);
			end else begin
				da[c] = sub(pt[1][c*COORD_BITS +: COORD_BITS], pt[0][c*COORD_BITS +: COORD_BITS]);
				db[c] = sub(pt[2][c*COORD_BITS +: COORD_BITS], pt[0][c*COORD_BITS +: COORD_BITS]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= da;
			b_s2   <= db;
			nrm_s2 <= nrm_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: the six partial products of the cross product.
	// ------------------------------------------------------------------
	logic signed [PROD_BITS-1:0] pr_s3 [6];
	logic                        v_s3;
	logic                        nrm_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s3[0] <= PROD_BITS'(a_s2[1]) * PROD_BITS'(b_s2[2]);
			pr_s3[1] <= PROD_BITS'(a_s2[2]) * PROD_BITS'(b_s2[1]);
			pr_s3[2] <= PROD_BITS'(a_s2[2]) * PROD_BITS'(b_s2[0]);
			pr_s3[3] <= PROD_BITS'(a_s2[0]) * PROD_BITS'(b_s2[2]);
			pr_s3[4] <= PROD_BITS'(a_s2[0]) * PROD_BITS'(b_s2[1]);
			pr_s3[5] <= PROD_BITS'(a_s2[1]) * PROD_BITS'(b_s2[0]);
			nrm_s3   <= nrm_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: cross product components.
	// ------------------------------------------------------------------
	logic signed [CROSS_BITS-1:0] cr_s4 [3];
	logic                         v_s4;
	logic                         nrm_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				cr_s4[k] <= CROSS_BITS'(pr_s3[2*k]) - CROSS_BITS'(pr_s3[2*k+1]);
			end
			nrm_s4 <= nrm_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: magnitudes, signs, zero test and the saturated raw value.
	// ------------------------------------------------------------------
	logic [OUT_BITS-1:0]   raw_c [3];
	logic [CROSS_BITS-1:0] mag_s5 [3];
	mfn_pkg::side_t        side_s5;
	logic                  v_s5;

	generate
		if (CROSS_BITS > OUT_BITS) begin : g_sat
			always_comb begin
				for (int k = 0; k < 3; k++) begin
					if ((&cr_s4[k][CROSS_BITS-1:OUT_BITS-1]) ||
							!(|cr_s4[k][CROSS_BITS-1:OUT_BITS-1])) begin
						raw_c[k] = cr_s4[k][OUT_BITS-1:0];
					end else if (cr_s4[k][CROSS_BITS-1]) begin
						raw_c[k] = {1'b1, {(OUT_BITS-1){1'b0}}};
					end else begin
						raw_c[k] = {1'b0, {(OUT_BITS-1){1'b1}}};
					end
				end
			end
		end else begin : g_ext
			always_comb begin
				for (int k = 0; k < 3; k++) begin
					raw_c[k] = OUT_BITS'(cr_s4[k]);
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				mag_s5[k]        <= cr_s4[k][CROSS_BITS-1] ? CROSS_BITS'(-cr_s4[k])
				                                           : CROSS_BITS'(cr_s4[k]);
				side_s5.neg[k]   <= cr_s4[k][CROSS_BITS-1];
				side_s5.raw[k]   <= raw_c[k];
			end
			side_s5.mag <= '0;
			side_s5.nrm <= nrm_s4;
			side_s5.deg <= (cr_s4[0] == '0) && (cr_s4[1] == '0) && (cr_s4[2] == '0);
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: right shift that brings the largest magnitude below 2^31.
	// ------------------------------------------------------------------
	logic [CROSS_BITS-1:0] mag_or;
	logic [SHIFT_BITS-1:0] sh_c;
	logic [SHIFT_BITS-1:0] sh_s6;
	logic [CROSS_BITS-1:0] mag_s6 [3];
	mfn_pkg::side_t        side_s6;
	logic                  v_s6;

	assign mag_or = mag_s5[0] | mag_s5[1] | mag_s5[2];

	always_comb begin
		sh_c = '0;
		for (int j = MAG_BITS; j < CROSS_BITS; j++) begin
			if (mag_or[j]) begin
				sh_c = SHIFT_BITS'(j - MAG_BITS + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s6   <= sh_c;
			mag_s6  <= mag_s5;
			side_s6 <= side_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: scaled magnitudes.
	// ------------------------------------------------------------------
	mfn_pkg::side_t side_s7;
	logic           v_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7.nrm <= side_s6.nrm;
			side_s7.deg <= side_s6.deg;
			side_s7.neg <= side_s6.neg;
			side_s7.raw <= side_s6.raw;
			for (int k = 0; k < 3; k++) begin
				side_s7.mag[k] <= MAG_BITS'(mag_s6[k] >> sh_s6);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: squares.
	// ------------------------------------------------------------------
	logic [SQ_BITS-1:0] sq_s8 [3];
	mfn_pkg::side_t     side_s8;
	logic               v_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s8[k] <= SQ_BITS'(side_s7.mag[k]) * SQ_BITS'(side_s7.mag[k]);
			end
			side_s8 <= side_s7;
		end
	end

	// ------------------------------------------------------------------
	// Square root: the sum enters at step 0, then one result bit per stage.
	// ------------------------------------------------------------------
	logic [ROOT_STEPS:0] rt_v_s;
	logic [SUM_BITS-1:0] rt_rem_s  [ROOT_STEPS+1];
	logic [SUM_BITS-1:0] rt_res_s  [ROOT_STEPS+1];
	mfn_pkg::side_t      rt_side_s [ROOT_STEPS+1];

	function automatic logic [2*SUM_BITS-1:0] root_step(input logic [SUM_BITS-1:0] rem,
			input logic [SUM_BITS-1:0] res, input int unsigned step);
		logic [SUM_BITS-1:0] bit_v;
		logic [SUM_BITS-1:0] trial;
		logic [SUM_BITS-1:0] rem_n;
		logic [SUM_BITS-1:0] res_n;
		bit_v = SUM_BITS'(1) << (SUM_BITS - 2 - 2 * step);
		trial = res + bit_v;
		if (rem >= trial) begin
			rem_n = rem - trial;
			res_n = (res >> 1) + bit_v;
		end else begin
			rem_n = rem;
			res_n = res >> 1;
		end
		return {rem_n, res_n};
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			rt_rem_s[0]  <= SUM_BITS'(sq_s8[0]) + SUM_BITS'(sq_s8[1]) + SUM_BITS'(sq_s8[2]);
			rt_res_s[0]  <= '0;
			rt_side_s[0] <= side_s8;
			for (int i = 0; i < ROOT_STEPS; i++) begin
				{rt_rem_s[i+1], rt_res_s[i+1]} <= root_step(rt_rem_s[i], rt_res_s[i], i);
				rt_side_s[i+1] <= rt_side_s[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Rounded division (m * 2^14 + L/2) / L: set up at step 0, then one
	// quotient bit per stage in each of the three lanes.
	// ------------------------------------------------------------------
	logic [QUOT_BITS:0]                 dv_v_s;
	logic [2:0][REM_BITS-1:0]           dv_rem_s  [QUOT_BITS+1];
	logic [2:0][QUOT_BITS-1:0]          dv_q_s    [QUOT_BITS+1];
	logic [ROOT_BITS-1:0]               dv_len_s  [QUOT_BITS+1];
	mfn_pkg::side_t                     dv_side_s [QUOT_BITS+1];
	logic [ROOT_BITS-1:0]               root_len;

	assign root_len = ROOT_BITS'(rt_res_s[ROOT_STEPS]);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dv_rem_s[0][k] <= (REM_BITS'(rt_side_s[ROOT_STEPS].mag[k]) << UNIT_SHIFT) +
				                  REM_BITS'(root_len >> 1);
			end
			dv_q_s[0]    <= '0;
			dv_len_s[0]  <= root_len;
			dv_side_s[0] <= rt_side_s[ROOT_STEPS];
			for (int j = 0; j < QUOT_BITS; j++) begin
				for (int k = 0; k < 3; k++) begin
					if (dv_rem_s[j][k] >= (REM_BITS'(dv_len_s[j]) << (QUOT_BITS - 1 - j))) begin
						dv_rem_s[j+1][k] <= dv_rem_s[j][k] -
						                    (REM_BITS'(dv_len_s[j]) << (QUOT_BITS - 1 - j));
						dv_q_s[j+1][k]   <= dv_q_s[j][k] | (QUOT_BITS'(1) << (QUOT_BITS - 1 - j));
					end else begin
						dv_rem_s[j+1][k] <= dv_rem_s[j][k];
						dv_q_s[j+1][k]   <= dv_q_s[j][k];
					end
				end
				dv_len_s[j+1]  <= dv_len_s[j];
				dv_side_s[j+1] <= dv_side_s[j];
			end
		end
	end

	// ------------------------------------------------------------------
	// Valid bits travel with the data.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			rt_v_s <= '0;
			dv_v_s <= '0;
		end else if (en) begin
			v_s1   <= accept && (op == mfn_pkg::OP_FACE) && normals_en_q;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
			rt_v_s <= {rt_v_s[ROOT_STEPS-1:0], v_s8};
			dv_v_s <= {dv_v_s[QUOT_BITS-1:0], rt_v_s[ROOT_STEPS]};
		end
	end

	// ------------------------------------------------------------------
	// Result selection: zero, unit normal or raw cross product.
	// ------------------------------------------------------------------
	mfn_pkg::side_t      fin_side;
	logic [OUT_BITS-1:0] fin_n [3];
	logic [OUT_BITS-1:0] unit_v;

	assign fin_side = dv_side_s[QUOT_BITS];

	always_comb begin
		unit_v = '0;
		for (int k = 0; k < 3; k++) begin
			unit_v = OUT_BITS'(dv_q_s[QUOT_BITS][k]);
			if (fin_side.deg) begin
				fin_n[k] = '0;
			end else if (fin_side.nrm) begin
				fin_n[k] = fin_side.neg[k] ? OUT_BITS'(-unit_v) : unit_v;
			end else begin
				fin_n[k] = fin_side.raw[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register with a skid stage behind it.
	// ------------------------------------------------------------------
	logic                push;
	logic                take;
	logic [OUT_BITS-1:0] out_n_q  [3];
	logic                out_deg_q;
	logic                out_nrm_q;
	logic [OUT_BITS-1:0] skid_n_q [3];
	logic                skid_deg_q;
	logic                skid_nrm_q;

	assign push = en && dv_v_s[QUOT_BITS];
	assign take = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q     <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (take) begin
				skid_full_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_v_q || take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_full_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (take) begin
				out_n_q   <= skid_n_q;
				out_deg_q <= skid_deg_q;
				out_nrm_q <= skid_nrm_q;
			end
		end else if (push) begin
			if (!out_v_q || take) begin
				out_n_q   <= fin_n;
				out_deg_q <= fin_side.deg;
				out_nrm_q <= fin_side.nrm;
			end else begin
				skid_n_q   <= fin_n;
				skid_deg_q <= fin_side.deg;
				skid_nrm_q <= fin_side.nrm;
			end
		end
	end

	assign out_valid  = out_v_q;
	assign normal_x   = out_n_q[0];
	assign normal_y   = out_n_q[1];
	assign normal_z   = out_n_q[2];
	assign degenerate = out_deg_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// The skid stage only holds an item behind a held output item.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_v_q)
		else $error("skid stage full while output register empty");

	// The skid stage fills only after the output was stalled.
	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_stall))
		else $error("skid stage filled without an output stall");

	// A degenerate face gives an all-zero normal.
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_deg_q) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
		else $error("degenerate item with non-zero normal");

	// A unit normal component never exceeds one in Q1.14.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_nrm_q && !out_deg_q) |->
		(normal_x <= 36'sd16384 && normal_x >= -36'sd16384 &&
		 normal_y <= 36'sd16384 && normal_y >= -36'sd16384 &&
		 normal_z <= 36'sd16384 && normal_z >= -36'sd16384))
		else $error("unit normal component out of range");

endmodule

// File: src/mfn_vtx_ram.sv
// ----------------------------------------------------------------------------
// Vertex table memory
// One write port and two registered read ports sharing a read enable.
// ----------------------------------------------------------------------------
module mfn_vtx_ram #(
	parameter int unsigned DEPTH     = mfn_pkg::VERTEX_DEPTH_DEF,
	parameter int unsigned WIDTH     = 3 * mfn_pkg::COORD_BITS_DEF,
	parameter int unsigned ADDR_BITS = $clog2(mfn_pkg::VERTEX_DEPTH_DEF)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [WIDTH-1:0]     wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr_a,
	input  logic [ADDR_BITS-1:0] rd_addr_b,
	output logic [WIDTH-1:0]     rd_data_a,
	output logic [WIDTH-1:0]     rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read ports; the read data holds while reads are disabled.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mesh face normal engine testbench
// Loads vertices and sends triangle and quad faces with random gaps on both
// channels. Each accepted face is predicted in the bench from its own copy of
// the vertex table and the two enables, and results are checked in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LATENCY     = 57;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TABLE_SLOTS = 4096;

	typedef struct {
		logic signed [35:0] nx;
		logic signed [35:0] ny;
		logic signed [35:0] nz;
		logic               deg;
	} normal_t;

	// Scoreboard: keeps the vertex table copy and the queue of expected normals.
	class normal_scoreboard;
		logic signed [15:0] vx [TABLE_SLOTS];
		logic signed [15:0] vy [TABLE_SLOTS];
		logic signed [15:0] vz [TABLE_SLOTS];
		bit                 faces_on = 1;
		bit                 unit_on  = 1;
		normal_t            pending[$];
		int                 mismatches;
		int                 checked;

		function automatic longint unsigned root64(longint unsigned s);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > s) b >>= 2;
			while (b != 0) begin
				if (s >= r + b) begin
					s -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// Record an accepted item; loads update the table, faces queue a normal.
		function automatic void note_item(bit f, int vi, logic [15:0] x, logic [15:0] y,
				logic [15:0] z, int ca, int cb, int cc, int cd, bit quad);
			longint a [3];
			longint b [3];
			longint n [3];
			longint p [4][3];
			int idx [4];
			longint unsigned m [3];
			longint unsigned len;
			longint q;
			normal_t r;
			if (!f) begin
				vx[vi] = x;
				vy[vi] = y;
				vz[vi] = z;
				return;
			end
			if (!faces_on) return;
			idx = '{ca, cb, cc, cd};
			for (int i = 0; i < 4; i++) begin
				p[i][0] = vx[idx[i]];
				p[i][1] = vy[idx[i]];
				p[i][2] = vz[idx[i]];
			end
			for (int k = 0; k < 3; k++) begin
				if (quad) begin
					a[k] = p[2][k] - p[0][k];
					b[k] = p[3][k] - p[1][k];
				end else begin
					a[k] = p[1][k] - p[0][k];
					b[k] = p[2][k] - p[0][k];
				end
			end
			n[0] = a[1] * b[2] - a[2] * b[1];
			n[1] = a[2] * b[0] - a[0] * b[2];
			n[2] = a[0] * b[1] - a[1] * b[0];
			r.deg = (n[0] == 0 && n[1] == 0 && n[2] == 0);
			if (r.deg) begin
				r.nx = '0;
				r.ny = '0;
				r.nz = '0;
			end else if (!unit_on) begin
				// Products of 17-bit differences stay inside 36 bits.
				r.nx = 36'(n[0]);
				r.ny = 36'(n[1]);
				r.nz = 36'(n[2]);
			end else begin
				for (int k = 0; k < 3; k++) m[k] = n[k] < 0 ? -n[k] : n[k];
				while (m[0] >= 64'd1 << 31 || m[1] >= 64'd1 << 31 || m[2] >= 64'd1 << 31)
					for (int k = 0; k < 3; k++) m[k] >>= 1;
				len = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
				if (len == 0) len = 1;
				for (int k = 0; k < 3; k++) begin
					q = (m[k] * 16384 + (len >> 1)) / len;
					n[k] = n[k] < 0 ? -q : q;
				end
				r.nx = 36'(n[0]);
				r.ny = 36'(n[1]);
				r.nz = 36'(n[2]);
			end
			pending.push_back(r);
		endfunction

		// Compare one result with the oldest expected normal.
		function automatic void check_result(normal_t got);
			normal_t w;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0d %0d %0d deg %0d",
					got.nx, got.ny, got.nz, got.deg);
				return;
			end
			w = pending.pop_front();
			checked++;
			if (w.nx !== got.nx || w.ny !== got.ny || w.nz !== got.nz || w.deg !== got.deg) begin
				mismatches++;
				if (mismatches <= 10)
					$display("normal mismatch: expected %0d %0d %0d deg %0d, got %0d %0d %0d deg %0d",
						w.nx, w.ny, w.nz, w.deg, got.nx, got.ny, got.nz, got.deg);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic op = 0;
	logic [11:0] vertex_index = 0;
	logic signed [15:0] coord_x = 0, coord_y = 0, coord_z = 0;
	logic [11:0] corner_a = 0, corner_b = 0, corner_c = 0, corner_d = 0;
	logic is_quad = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [35:0] normal_x, normal_y, normal_z;
	logic degenerate;
	logic cfg_write = 0;
	logic [0:0] cfg_index = 0;
	logic [0:0] cfg_data = 0;

	normal_scoreboard board;
	int  cycles;
	int  loaded [$];
	bit  written [TABLE_SLOTS];
	int  faces_sent;
	bit  sink_stress;

	mesh_face_normal_engine_core dut (.*);

	initial forever #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at cycle %0d", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side: sample at the rising edge, draw stalls at the falling edge.
	always @(posedge clk) begin
		normal_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.nx = normal_x;
			got.ny = normal_y;
			got.nz = normal_z;
			got.deg = degenerate;
			board.check_result(got);
		end
	end

	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				gap = sink_stress ? $urandom_range(0, 9) : 0;
				if (gap != 0) begin
					out_stall <= 1;
					repeat (gap) @(negedge clk);
					out_stall <= 0;
				end
			end
		end
	end

	// Send one item and wait for its acceptance.
	task automatic send_item(bit f, int vi, logic [15:0] x, logic [15:0] y, logic [15:0] z,
			int ca, int cb, int cc, int cd, bit quad, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		op <= f ? mfn_pkg::OP_FACE : mfn_pkg::OP_LOAD;
		vertex_index <= 12'(vi);
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		corner_a <= 12'(ca);
		corner_b <= 12'(cb);
		corner_c <= 12'(cc);
		corner_d <= 12'(cd);
		is_quad <= quad;
		do @(posedge clk); while (in_stall);
		board.note_item(f, vi, x, y, z, ca, cb, cc, cd, quad);
		if (!f && !written[vi]) begin
			written[vi] = 1;
			loaded.push_back(vi);
		end
		if (f) faces_sent++;
		@(negedge clk);
	endtask

	task automatic load(int vi, logic [15:0] x, logic [15:0] y, logic [15:0] z, bit gaps);
		send_item(0, vi, x, y, z, $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 4095), 1'($urandom_range(0, 1)), gaps);
	endtask

	task automatic face(int ca, int cb, int cc, int cd, bit quad, bit gaps);
		send_item(1, $urandom_range(0, 4095), 16'($urandom), 16'($urandom), 16'($urandom),
			ca, cb, cc, cd, quad, gaps);
	endtask

	function automatic int any_loaded();
		return loaded[$urandom_range(0, loaded.size() - 1)];
	endfunction

	// Wait until the pipeline has drained, then write both registers.
	task automatic set_mode(bit faces_on, bit unit_on);
		in_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
		cfg_write <= 1;
		cfg_index <= mfn_pkg::REG_NORMALS_ENABLE;
		cfg_data <= faces_on;
		@(negedge clk);
		cfg_index <= mfn_pkg::REG_NORMALIZE_ENABLE;
		cfg_data <= unit_on;
		@(negedge clk);
		cfg_write <= 0;
		board.faces_on = faces_on;
		board.unit_on = unit_on;
	endtask

	task automatic random_phase(int count);
		int c [4];
		for (int i = 0; i < count; i++) begin
			sink_stress = (i / 100) % 3 != 0;
			if ($urandom_range(0, 3) == 0 || loaded.size() < 4) begin
				case ($urandom_range(0, 3))
					0: load($urandom_range(0, 4095), 16'($urandom), 16'($urandom), 16'($urandom),
						(i / 50) % 4 != 0);
					1: load(any_loaded(), 16'($urandom), 16'($urandom), 16'($urandom),
						(i / 50) % 4 != 0);
					2: load($urandom_range(0, 4095), $urandom_range(0, 1) ? 16'h8000 : 16'h7fff,
						$urandom_range(0, 1) ? 16'h8000 : 16'h7fff,
						$urandom_range(0, 1) ? 16'h8000 : 16'h7fff, 1);
					default: load($urandom_range(0, 4095), 16'($urandom_range(0, 63) - 32),
						16'($urandom_range(0, 63) - 32), 16'($urandom_range(0, 63) - 32), 1);
				endcase
			end else begin
				for (int k = 0; k < 4; k++) c[k] = any_loaded();
				// Repeated corners now and then give degenerate faces.
				if ($urandom_range(0, 9) == 0) c[2] = c[0];
				face(c[0], c[1], c[2], c[3], 1'($urandom_range(0, 1)), (i / 50) % 4 != 0);
			end
		end
	endtask

	initial begin
		board = new();
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes, both face shapes, degenerate and disabled faces.
		load(0, 16'h8000, 16'h8000, 16'h8000, 0);
		load(4095, 16'h7fff, 16'h7fff, 16'h7fff, 0);
		load(1, 16'h7fff, 16'h8000, 16'h0000, 0);
		load(2, 16'h0000, 16'h7fff, 16'h8000, 0);
		load(3, 16'h0100, 16'h0000, 16'h0000, 0);
		load(4, 16'h0000, 16'h0100, 16'h0000, 0);
		load(5, 16'h0000, 16'h0000, 16'h0000, 0);
		face(5, 3, 4, 0, 0, 0);
		face(0, 1, 4095, 2, 1, 0);
		face(0, 1, 2, 4095, 0, 0);
		face(0, 0, 4095, 4095, 0, 0);
		face(3, 3, 3, 3, 1, 0);
		face(5, 3, 4, 0, 1, 0);
		set_mode(1, 0);
		face(0, 1, 4095, 2, 1, 0);
		face(0, 1, 2, 4095, 0, 0);
		face(5, 3, 4, 0, 0, 0);
		face(4, 4, 4, 4, 0, 0);
		set_mode(0, 1);
		face(0, 1, 2, 4095, 0, 0);
		load(6, 16'h0055, 16'hffaa, 16'h1234, 0);
		set_mode(1, 1);

		random_phase(500);
		set_mode(1, 0);
		random_phase(400);
		set_mode(0, 0);
		random_phase(100);
		set_mode(1, 1);
		random_phase(500);

		in_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
		$display("Sent %0d faces over %0d table slots; %0d normals checked.",
			faces_sent, loaded.size(), board.checked);
		$display("Modes covered: unit and raw normals, faces disabled, random stalls.");
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", board.mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
